### design/bol_pkg.sv
package bol_pkg;

    localparam int DATA_W   = 32;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;

    localparam logic [CMD_W-1:0] CMD_APPEND  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PREPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DUMP    = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_DONE      = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_ELEMENT   = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] element;
        logic                     last_of_run;
    } out_item_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_APPEND,
        CELL_PREPEND,
        CELL_DELETE,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     occ;
        logic     tail;
    } cell_ctl_t;

endpackage

### design/bounded_ordered_list.sv
// Append, prepend and delete leave busy low: a new item may start in every cycle, with
// its single result strobed in the cycle after acceptance. A dump of a non-empty list
// rotates the cell chain once round, holding busy high meanwhile, and the stored
// entries appear one per cycle, head first.
// The receiver cannot stall, so no result ever waits. Reset empties the list at once;
// cell contents are not cleared.
module bounded_ordered_list #(
    parameter int CAPACITY = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  bol_pkg::in_item_t  command,
    output logic               strobe,
    output bol_pkg::out_item_t result
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } state_t;

    state_t                           state_reg, state_next;
    logic [CNT_W-1:0]                 count_reg, count_next;
    logic [CNT_W-1:0]                 step_reg, step_next;
    logic                             strobe_reg, strobe_next;
    bol_pkg::out_item_t               result_reg, result_next;

    bol_pkg::cell_op_t                op;
    bol_pkg::cell_ctl_t               ctl [CAPACITY];
    logic signed [bol_pkg::DATA_W-1:0] data [CAPACITY];
    logic [CAPACITY:0]                hit;
    logic                             accept;
    logic                             full;
    logic                             empty;

    assign accept = start & (state_reg == ST_IDLE);
    assign full   = (count_reg == CNT_W'(CAPACITY));
    assign empty  = (count_reg == '0);
    assign hit[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic signed [bol_pkg::DATA_W-1:0] left_d;
            logic signed [bol_pkg::DATA_W-1:0] right_d;

            assign ctl[gi].op   = op;
            assign ctl[gi].occ  = (CNT_W'(gi) < count_reg);
            assign ctl[gi].tail = (CNT_W'(gi) == count_reg);

            if (gi == 0)
            begin : g_head
                assign left_d = command.value;
            end
            else
            begin : g_body
                assign left_d = data[gi-1];
            end

            // The tail cell wraps round to the head so that a dump restores the list.
            if (gi == CAPACITY - 1)
            begin : g_tail
                assign right_d = data[0];
            end
            else
            begin : g_inner
                assign right_d = data[gi+1];
            end

            bol_cell u_cell (
                .clk        (clk),
                .ctl        (ctl[gi]),
                .value      (command.value),
                .left_data  (left_d),
                .right_data (right_d),
                .hit_in     (hit[gi]),
                .hit_out    (hit[gi+1]),
                .data       (data[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        step_next   = step_reg;
        strobe_next = 1'b0;
        result_next = result_reg;
        op          = bol_pkg::CELL_HOLD;

        if (state_reg == ST_DUMP)
        begin
            op        = bol_pkg::CELL_ROTATE;
            step_next = step_reg + 1'b1;
            if (step_reg < count_reg)
            begin
                strobe_next             = 1'b1;
                result_next.status      = bol_pkg::STAT_ELEMENT;
                result_next.element     = data[0];
                result_next.last_of_run = (step_reg == count_reg - 1'b1);
            end
            if (step_reg == CNT_W'(CAPACITY - 1))
            begin
                state_next = ST_IDLE;
            end
        end
        else if (accept)
        begin
            strobe_next             = 1'b1;
            result_next.element     = '0;
            result_next.last_of_run = 1'b1;
            result_next.status      = bol_pkg::STAT_DONE;
            case (command.cmd)
                bol_pkg::CMD_APPEND, bol_pkg::CMD_PREPEND:
                begin
                    if (full)
                    begin
                        result_next.status = bol_pkg::STAT_FULL;
                    end
                    else
                    begin
                        op = (command.cmd == bol_pkg::CMD_APPEND) ? bol_pkg::CELL_APPEND
                                                                  : bol_pkg::CELL_PREPEND;
                        count_next = count_reg + 1'b1;
                    end
                end
                bol_pkg::CMD_DELETE:
                begin
                    if (empty)
                    begin
                        result_next.status = bol_pkg::STAT_EMPTY;
                    end
                    else if (hit[CAPACITY])
                    begin
                        op         = bol_pkg::CELL_DELETE;
                        count_next = count_reg - 1'b1;
                    end
                    else
                    begin
                        result_next.status = bol_pkg::STAT_NOT_FOUND;
                    end
                end
                default:
                begin
                    if (empty)
                    begin
                        result_next.status = bol_pkg::STAT_EMPTY;
                    end
                    else
                    begin
                        // The dump's results come from the rotation that follows.
                        strobe_next = 1'b0;
                        state_next  = ST_DUMP;
                        step_next   = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            step_reg   <= '0;
            strobe_reg <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            step_reg   <= step_next;
            strobe_reg <= strobe_next;
            result_reg <= result_next;
        end
    end

    assign busy   = (state_reg == ST_DUMP);
    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

### design/bol_cell.sv
module bol_cell (
    input  logic                              clk,
    input  bol_pkg::cell_ctl_t                ctl,
    input  logic signed [bol_pkg::DATA_W-1:0] value,
    input  logic signed [bol_pkg::DATA_W-1:0] left_data,
    input  logic signed [bol_pkg::DATA_W-1:0] right_data,
    input  logic                              hit_in,
    output logic                              hit_out,
    output logic signed [bol_pkg::DATA_W-1:0] data
);

    logic signed [bol_pkg::DATA_W-1:0] data_reg;
    logic signed [bol_pkg::DATA_W-1:0] data_next;

    // A cell at or behind the first match pulls its right neighbour in on a delete.
    assign hit_out = hit_in | (ctl.occ & (data_reg == value));
    assign data    = data_reg;

    always_comb
    begin
        data_next = data_reg;
        case (ctl.op)
            bol_pkg::CELL_APPEND:
            begin
                if (ctl.tail)
                begin
                    data_next = value;
                end
            end
            bol_pkg::CELL_PREPEND: data_next = left_data;
            bol_pkg::CELL_DELETE:
            begin
                if (hit_out)
                begin
                    data_next = right_data;
                end
            end
            bol_pkg::CELL_ROTATE: data_next = right_data;
            default: data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

### verif/bounded_ordered_list_test.sv
module bounded_ordered_list_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY       = 16;
    localparam int ITEM_COUNT     = 348;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = CAPACITY + 8;
    localparam int FILL_W         = $clog2(CAPACITY + 1);

    typedef struct {
        bol_pkg::in_item_t            item;
        int                           reps;
        bit                           typed;
        logic [bol_pkg::STATUS_W-1:0] want;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    bol_pkg::in_item_t  command = '0;
    logic               busy;
    logic               strobe;
    bol_pkg::out_item_t result;

    // Our own copy of the list, head in cell 0.
    logic signed [bol_pkg::DATA_W-1:0] list_cells [CAPACITY];
    logic [FILL_W-1:0]                 list_fill = '0;
    bol_pkg::out_item_t                expected_results [$];

    int items_sent = 0;
    int results_checked = 0;
    int mismatches = 0;
    int quiet_cycles = 0;
    int status_tally [5] = '{default: 0};

    // The typed expectations are single results with element zero and the last mark set.
    stim_row_t directed_rows [20] = '{
        '{'{bol_pkg::CMD_DUMP,    32'h0000_0000}, 1, 1'b1, bol_pkg::STAT_EMPTY},
        '{'{bol_pkg::CMD_DELETE,  32'h0000_0005}, 1, 1'b1, bol_pkg::STAT_EMPTY},
        '{'{bol_pkg::CMD_APPEND,  32'h7fff_ffff}, 1, 1'b1, bol_pkg::STAT_DONE},
        '{'{bol_pkg::CMD_PREPEND, 32'h8000_0000}, 1, 1'b1, bol_pkg::STAT_DONE},
        '{'{bol_pkg::CMD_APPEND,  32'h0000_0000}, 1, 1'b1, bol_pkg::STAT_DONE},
        '{'{bol_pkg::CMD_APPEND,  32'hffff_ffff}, 1, 1'b1, bol_pkg::STAT_DONE},
        '{'{bol_pkg::CMD_DUMP,    32'h0000_0000}, 1, 1'b0, bol_pkg::STAT_ELEMENT},
        '{'{bol_pkg::CMD_DELETE,  32'h0000_3039}, 1, 1'b1, bol_pkg::STAT_NOT_FOUND},
        '{'{bol_pkg::CMD_DELETE,  32'h8000_0000}, 1, 1'b1, bol_pkg::STAT_DONE},
        '{'{bol_pkg::CMD_DELETE,  32'hffff_ffff}, 1, 1'b1, bol_pkg::STAT_DONE},
        '{'{bol_pkg::CMD_DUMP,    32'h0000_0000}, 1, 1'b0, bol_pkg::STAT_ELEMENT},
        '{'{bol_pkg::CMD_APPEND,  32'h5555_5555}, 7, 1'b1, bol_pkg::STAT_DONE},
        '{'{bol_pkg::CMD_PREPEND, 32'haaaa_aaaa}, 7, 1'b1, bol_pkg::STAT_DONE},
        '{'{bol_pkg::CMD_APPEND,  32'h0000_0001}, 1, 1'b1, bol_pkg::STAT_FULL},
        '{'{bol_pkg::CMD_PREPEND, 32'h0000_0002}, 1, 1'b1, bol_pkg::STAT_FULL},
        '{'{bol_pkg::CMD_DUMP,    32'h0000_0000}, 1, 1'b0, bol_pkg::STAT_ELEMENT},
        '{'{bol_pkg::CMD_DELETE,  32'h5555_5555}, 1, 1'b1, bol_pkg::STAT_DONE},
        '{'{bol_pkg::CMD_DELETE,  32'h7fff_ffff}, 1, 1'b1, bol_pkg::STAT_DONE},
        '{'{bol_pkg::CMD_PREPEND, 32'hffff_ffff}, 1, 1'b0, bol_pkg::STAT_DONE},
        '{'{bol_pkg::CMD_DUMP,    32'hffff_ffff}, 1, 1'b0, bol_pkg::STAT_ELEMENT}
    };

    bounded_ordered_list #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .command (command),
        .strobe  (strobe),
        .result  (result)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic void queue_result(logic [bol_pkg::STATUS_W-1:0] status,
                                         logic signed [bol_pkg::DATA_W-1:0] element,
                                         logic last);
        bol_pkg::out_item_t r;
        r.status      = status;
        r.element     = element;
        r.last_of_run = last;
        expected_results.push_back(r);
        status_tally[status]++;
    endfunction

    function automatic void apply_list_command(bol_pkg::in_item_t it);
        int idx;
        int hit;
        case (it.cmd)
            bol_pkg::CMD_APPEND, bol_pkg::CMD_PREPEND:
            begin
                if (list_fill == CAPACITY)
                    queue_result(bol_pkg::STAT_FULL, '0, 1'b1);
                else
                begin
                    if (it.cmd == bol_pkg::CMD_APPEND)
                        list_cells[list_fill] = it.value;
                    else
                    begin
                        for (idx = list_fill; idx > 0; idx--)
                            list_cells[idx] = list_cells[idx - 1];
                        list_cells[0] = it.value;
                    end
                    list_fill++;
                    queue_result(bol_pkg::STAT_DONE, '0, 1'b1);
                end
            end
            bol_pkg::CMD_DELETE:
            begin
                hit = -1;
                for (idx = 0; idx < list_fill; idx++)
                    if (hit < 0 && list_cells[idx] == it.value)
                        hit = idx;
                if (list_fill == 0)
                    queue_result(bol_pkg::STAT_EMPTY, '0, 1'b1);
                else if (hit < 0)
                    queue_result(bol_pkg::STAT_NOT_FOUND, '0, 1'b1);
                else
                begin
                    for (idx = hit; idx + 1 < list_fill; idx++)
                        list_cells[idx] = list_cells[idx + 1];
                    list_fill--;
                    queue_result(bol_pkg::STAT_DONE, '0, 1'b1);
                end
            end
            default:
            begin
                if (list_fill == 0)
                    queue_result(bol_pkg::STAT_EMPTY, '0, 1'b1);
                for (idx = 0; idx < list_fill; idx++)
                    queue_result(bol_pkg::STAT_ELEMENT, list_cells[idx],
                                 idx + 1 == list_fill);
            end
        endcase
    endfunction

    // Small values give plenty of duplicates, so the first-match rule gets exercised.
    function automatic logic signed [bol_pkg::DATA_W-1:0] random_value();
        case ($urandom_range(9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2, 3, 4: return $urandom_range(7);
            default: return $urandom;
        endcase
    endfunction

    // Waits out an optional gap, then holds the item until the block takes it.
    task automatic send_item(bol_pkg::in_item_t it, int idle_pct);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start   <= 1'b1;
        command <= it;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        items_sent++;
    endtask

    task automatic note_mismatch(string what, bol_pkg::out_item_t want,
                                 bol_pkg::out_item_t got);
        mismatches++;
        if (mismatches <= 10)
            $display({"%0t: %s: expected status %0d element %0d last %0b, ",
                      "got status %0d element %0d last %0b"},
                     $realtime, what, want.status, want.element, want.last_of_run,
                     got.status, got.element, got.last_of_run);
    endtask

    always @(posedge clk)
    begin
        bol_pkg::out_item_t want;
        if (rst_n && strobe !== 1'b0)
        begin
            results_checked++;
            if (expected_results.size() == 0)
                note_mismatch("result with nothing outstanding", '0, result);
            else
            begin
                want = expected_results.pop_front();
                if (result.status !== want.status || result.element !== want.element ||
                    result.last_of_run !== want.last_of_run)
                    note_mismatch("result mismatch", want, result);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || strobe)
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("bounded_ordered_list_test: FAIL");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int                 base;
        int                 pick;
        int                 trend_left;
        bit                 filling;
        bol_pkg::in_item_t  it;
        int                 idle_pct [3] = '{0, 65, 20};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r])
        begin
            for (int n = 0; n < directed_rows[r].reps; n++)
            begin
                send_item(directed_rows[r].item, 0);
                base = expected_results.size();
                apply_list_command(directed_rows[r].item);
                if (directed_rows[r].typed)
                begin
                    while (expected_results.size() > base)
                        void'(expected_results.pop_back());
                    expected_results.push_back('{directed_rows[r].want, '0, 1'b1});
                end
            end
        end

        // Alternate filling and draining stretches so the list keeps reaching
        // both the full and the empty state.
        filling    = 1'b1;
        trend_left = $urandom_range(20, 60);
        for (int phase = 0; phase < 3; phase++)
        begin
            for (int k = 0; k < ITEM_COUNT / 3; k++)
            begin
                if (trend_left == 0)
                begin
                    filling    = !filling;
                    trend_left = $urandom_range(20, 60);
                end
                trend_left--;
                pick     = $urandom_range(99);
                it.value = random_value();
                if (pick < (filling ? 35 : 10))
                    it.cmd = bol_pkg::CMD_APPEND;
                else if (pick < (filling ? 70 : 20))
                    it.cmd = bol_pkg::CMD_PREPEND;
                else if (pick < 85)
                begin
                    it.cmd = bol_pkg::CMD_DELETE;
                    if (list_fill != 0 && $urandom_range(99) < 70)
                        it.value = list_cells[$urandom_range(list_fill - 1)];
                end
                else
                    it.cmd = bol_pkg::CMD_DUMP;
                send_item(it, idle_pct[phase]);
                apply_list_command(it);
            end
        end
        start <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d items and checked %0d results: %0d dumped entries, %0d %s",
                 items_sent, results_checked, status_tally[bol_pkg::STAT_ELEMENT],
                 status_tally[bol_pkg::STAT_EMPTY], "empty-list replies,");
        $display("%0d inserts dropped on a full list and %0d deletes that found no match.",
                 status_tally[bol_pkg::STAT_FULL], status_tally[bol_pkg::STAT_NOT_FOUND]);
        if (mismatches == 0)
            $display("bounded_ordered_list_test: PASS");
        else
            $display("bounded_ordered_list_test: FAIL");
        $finish;
    end

endmodule
